[hdl/rsg_pkg.sv]
`default_nettype none
package rsg_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_IDX_W      = 4;
  localparam int RC_W           = 7;
  localparam int RAD_W          = 31;
  localparam int XW             = 36;
  localparam int ZW             = 32;
  localparam int SH_W           = 5;
  localparam int ITER_W         = 5;
  localparam int CORDIC_STEPS   = 24;
  localparam int MUL_STEPS      = 5;
  localparam int MAX_RING_DEF   = 64;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int RING_COUNT_RST = 8;

  localparam logic [RAD_W-1:0] INV_GAIN_Q31 = 31'd1304065748;
  localparam logic signed [XW-1:0] UNIT_Q30 = 36'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_RADIUS = 4'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_FOLD,
    OP_VEC,
    OP_SPD_LO,
    OP_SPD_HI,
    OP_SPD_END,
    OP_SPD_SAT,
    OP_DIV_INIT,
    OP_DIV,
    OP_ROT_INIT,
    OP_ROT,
    OP_ROT_FIX,
    OP_MUL,
    OP_EMIT
  } rsg_op_t;

  typedef struct packed {
    rsg_op_t           op;
    logic [ITER_W-1:0] iter;
  } rsg_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic vel_zero;
    logic last_member;
  } rsg_status_t;

  function automatic logic [ZW-1:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [ZW-1:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10680862;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [XW-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/rsg_if.sv]
`default_nettype none
interface rsg_obj_if;
  import rsg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  modport source (output valid, origin_x, origin_y, vel_x, vel_y, input ready);
  modport sink (input valid, origin_x, origin_y, vel_x, vel_y, output ready);
endinterface

interface rsg_ring_if;
  import rsg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] out_vel_x;
  logic signed [DATA_W-1:0] out_vel_y;
  logic                     last;
  modport source (output valid, pos_x, pos_y, out_vel_x, out_vel_y, last, input ready);
  modport sink (input valid, pos_x, pos_y, out_vel_x, out_vel_y, last, output ready);
endinterface

interface rsg_cfg_if;
  import rsg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/rsg_ctrl.sv]
`default_nettype none
module rsg_ctrl #(
  parameter int ANGLE_BITS = rsg_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output rsg_pkg::rsg_cmd_t        cmd,
  input  wire rsg_pkg::rsg_status_t status
);
  import rsg_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_NORM     = 15'b000000000000010,
    S_FOLD     = 15'b000000000000100,
    S_VEC      = 15'b000000000001000,
    S_SPD_LO   = 15'b000000000010000,
    S_SPD_HI   = 15'b000000000100000,
    S_SPD_END  = 15'b000000001000000,
    S_SPD_SAT  = 15'b000000010000000,
    S_DIV_INIT = 15'b000000100000000,
    S_DIV      = 15'b000001000000000,
    S_ROT_INIT = 15'b000010000000000,
    S_ROT      = 15'b000100000000000,
    S_ROT_FIX  = 15'b001000000000000,
    S_MUL      = 15'b010000000000000,
    S_EMIT     = 15'b100000000000000
  } state_t;

  state_t            state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;
  logic              emit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd.iter   = iter;
    cmd.op     = OP_NONE;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (status.vel_zero) begin
          state_next = S_DIV_INIT;
        end else if (status.norm_done) begin
          state_next = S_FOLD;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_FOLD: begin
        cmd.op     = OP_FOLD;
        iter_next  = '0;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.op = OP_VEC;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          state_next = S_SPD_LO;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_SPD_LO: begin
        cmd.op     = OP_SPD_LO;
        state_next = S_SPD_HI;
      end
      S_SPD_HI: begin
        cmd.op     = OP_SPD_HI;
        state_next = S_SPD_END;
      end
      S_SPD_END: begin
        cmd.op     = OP_SPD_END;
        state_next = S_SPD_SAT;
      end
      S_SPD_SAT: begin
        cmd.op     = OP_SPD_SAT;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        iter_next  = ITER_W'(ANGLE_BITS);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (iter == '0) begin
          state_next = S_ROT_INIT;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_ROT_INIT: begin
        cmd.op     = OP_ROT_INIT;
        iter_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          state_next = S_ROT_FIX;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_ROT_FIX: begin
        cmd.op     = OP_ROT_FIX;
        iter_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (iter == ITER_W'(MUL_STEPS - 1)) begin
          state_next = S_EMIT;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_EMIT;
          emit       = 1'b1;
          state_next = status.last_member ? S_IDLE : S_ROT_INIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

[hdl/rsg_dp.sv]
`default_nettype none
module rsg_dp #(
  parameter int MAX_RING   = rsg_pkg::MAX_RING_DEF,
  parameter int ANGLE_BITS = rsg_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [rsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsg_pkg::DATA_W-1:0]       cfg_data,
  input  wire logic signed [rsg_pkg::DATA_W-1:0] in_origin_x,
  input  wire logic signed [rsg_pkg::DATA_W-1:0] in_origin_y,
  input  wire logic signed [rsg_pkg::DATA_W-1:0] in_vel_x,
  input  wire logic signed [rsg_pkg::DATA_W-1:0] in_vel_y,
  output logic signed [rsg_pkg::DATA_W-1:0]     pos_x,
  output logic signed [rsg_pkg::DATA_W-1:0]     pos_y,
  output logic signed [rsg_pkg::DATA_W-1:0]     out_vel_x,
  output logic signed [rsg_pkg::DATA_W-1:0]     out_vel_y,
  output logic                                  last,
  input  wire rsg_pkg::rsg_cmd_t                cmd,
  output rsg_pkg::rsg_status_t                  status
);
  import rsg_pkg::*;

  localparam int NW = $clog2(MAX_RING + 1);
  localparam int AB = ANGLE_BITS;
  localparam logic [ZW-1:0] ANG_RND = ZW'(1) << (31 - AB);

  logic [RC_W-1:0]  ring_count;
  logic [RAD_W-1:0] ring_radius;

  logic signed [DATA_W-1:0] held_origin_x, held_origin_y;
  logic signed [XW-1:0]     x, y;
  logic [ZW-1:0]            z;
  logic [SH_W-1:0]          sh;
  logic                     flip;
  logic signed [66:0]       prod;
  logic [63:0]              acc;
  logic [AB-1:0]            base_angle;
  logic [DATA_W-1:0]        held_speed;
  logic [NW-1:0]            n, rem, acc_r, member_index;
  logic [AB-1:0]            q0, acc_q;
  logic signed [DATA_W-1:0] res_px, res_py, res_vx, res_vy;

  logic signed [XW-1:0] ax, ay, mx, xs, ys;
  logic                 mag_low;
  logic signed [32:0]   mul_a;
  logic signed [33:0]   mul_b;
  logic signed [66:0]   rnd;
  logic signed [XW-1:0] scaled;
  logic [ZW-1:0]        zr, zz;
  logic [AB-1:0]        ang;
  logic [NW:0]          rem_sh, r_sum;
  logic [63:0]          spd_sh;
  logic [NW-1:0]        n_cl;

  assign ax      = x[XW-1] ? -x : x;
  assign ay      = y[XW-1] ? -y : y;
  assign mx      = (ax > ay) ? ax : ay;
  assign mag_low = (mx < 36'sh0_4000_0000);
  assign xs      = x >>> cmd.iter;
  assign ys      = y >>> cmd.iter;
  assign rnd     = prod + 67'sd536870912;
  assign scaled  = rnd[65:30];
  assign zr      = z + ANG_RND;
  assign ang     = base_angle + acc_q;
  assign zz      = {ang, {(ZW - AB){1'b0}}};
  assign rem_sh  = {rem, (cmd.iter == ITER_W'(AB))};
  assign r_sum   = {1'b0, acc_r} + {1'b0, rem};
  assign spd_sh  = acc >> (6'd31 + {1'b0, sh});

  assign status.vel_zero    = (mx == '0);
  assign status.norm_done   = !mag_low;
  assign status.last_member = (member_index == n - 1'b1);

  always_comb begin
    if (ring_count == '0) begin
      n_cl = NW'(1);
    end else if (ring_count > RC_W'(MAX_RING)) begin
      n_cl = NW'(MAX_RING);
    end else begin
      n_cl = NW'(ring_count);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SPD_LO: begin
        mul_a = {2'b0, INV_GAIN_Q31};
        mul_b = {18'b0, x[15:0]};
      end
      OP_SPD_HI: begin
        mul_a = {2'b0, INV_GAIN_Q31};
        mul_b = {14'b0, x[XW-1:16]};
      end
      OP_MUL: begin
        mul_a = (cmd.iter < ITER_W'(2)) ? {2'b0, ring_radius} : {1'b0, held_speed};
        mul_b = cmd.iter[0] ? y[33:0] : x[33:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count  <= RC_W'(RING_COUNT_RST);
      ring_radius <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RING_COUNT:  ring_count  <= cfg_data[RC_W-1:0];
        REG_RING_RADIUS: ring_radius <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        held_origin_x <= in_origin_x;
        held_origin_y <= in_origin_y;
        x             <= XW'(in_vel_x);
        y             <= XW'(in_vel_y);
        sh            <= '0;
        base_angle    <= '0;
        held_speed    <= '0;
        n             <= n_cl;
      end
      OP_NORM: begin
        if (mag_low) begin
          x  <= x <<< 1;
          y  <= y <<< 1;
          sh <= sh + 1'b1;
        end
      end
      OP_FOLD: begin
        if (x[XW-1]) begin
          x <= -x;
          y <= -y;
          z <= 32'h8000_0000;
        end else begin
          z <= '0;
        end
      end
      OP_VEC: begin
        if (!y[XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_turn(cmd.iter);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_turn(cmd.iter);
        end
      end
      OP_SPD_LO: begin
        base_angle <= zr[ZW-1 -: AB];
      end
      OP_SPD_HI: begin
        acc <= prod[63:0];
      end
      OP_SPD_END: begin
        acc <= acc + {prod[47:0], 16'b0} + (64'd1 << (6'd30 + {1'b0, sh}));
      end
      OP_SPD_SAT: begin
        held_speed <= (|spd_sh[63:32]) ? '1 : spd_sh[31:0];
      end
      OP_DIV_INIT: begin
        rem          <= '0;
        q0           <= '0;
        acc_q        <= '0;
        acc_r        <= '0;
        member_index <= '0;
      end
      OP_DIV: begin
        if (rem_sh >= {1'b0, n}) begin
          rem <= NW'(rem_sh - {1'b0, n});
          q0  <= {q0[AB-2:0], 1'b1};
        end else begin
          rem <= rem_sh[NW-1:0];
          q0  <= {q0[AB-2:0], 1'b0};
        end
      end
      OP_ROT_INIT: begin
        flip <= zz[31] ^ zz[30];
        z    <= {zz[31] ^ zz[30] ^ zz[31], zz[30:0]};
        x    <= UNIT_Q30;
        y    <= '0;
      end
      OP_ROT: begin
        if (!z[ZW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_turn(cmd.iter);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_turn(cmd.iter);
        end
      end
      OP_ROT_FIX: begin
        if (flip) begin
          x <= -x;
          y <= -y;
        end
      end
      OP_MUL: begin
        unique case (cmd.iter)
          ITER_W'(1): res_px <= sat32(XW'(held_origin_x) + scaled);
          ITER_W'(2): res_py <= sat32(XW'(held_origin_y) + scaled);
          ITER_W'(3): res_vx <= sat32(scaled);
          default: begin
          end
        endcase
        if (cmd.iter == ITER_W'(4)) begin
          res_vy <= sat32(scaled);
        end
      end
      OP_EMIT: begin
        pos_x        <= res_px;
        pos_y        <= res_py;
        out_vel_x    <= res_vx;
        out_vel_y    <= res_vy;
        last         <= status.last_member;
        member_index <= member_index + 1'b1;
        if (r_sum >= {1'b0, n}) begin
          acc_r <= NW'(r_sum - {1'b0, n});
          acc_q <= acc_q + q0 + 1'b1;
        end else begin
          acc_r <= r_sum[NW-1:0];
          acc_q <= acc_q + q0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/ring_spawn_generator.sv]
`default_nettype none
// after an input transaction the velocity is normalized by a shift count s (0..30) before
// the first result is computed; zero velocity skips the normalize, vectoring and speed steps
// each further ring member takes another pass through the shared 24-step cordic unit
// a new input is taken only once the last member of the ring has been emitted
// synchronous active-high reset clears the controller, the output valid and the registers
// to ring_count 8 and ring_radius 0
module ring_spawn_generator #(
  parameter int MAX_RING   = rsg_pkg::MAX_RING_DEF,
  parameter int ANGLE_BITS = rsg_pkg::ANGLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rsg_obj_if.sink     obj_in,
  rsg_ring_if.source  ring_out,
  rsg_cfg_if.sink     cfg
);
  import rsg_pkg::*;

  rsg_cmd_t    cmd;
  rsg_status_t status;

  assign cfg.ready = 1'b1;

  rsg_ctrl #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (obj_in.valid),
    .in_ready (obj_in.ready),
    .out_ready(ring_out.ready),
    .out_valid(ring_out.valid),
    .cmd      (cmd),
    .status   (status)
  );

  rsg_dp #(
    .MAX_RING  (MAX_RING),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .in_origin_x(obj_in.origin_x),
    .in_origin_y(obj_in.origin_y),
    .in_vel_x   (obj_in.vel_x),
    .in_vel_y   (obj_in.vel_y),
    .pos_x      (ring_out.pos_x),
    .pos_y      (ring_out.pos_y),
    .out_vel_x  (ring_out.out_vel_x),
    .out_vel_y  (ring_out.out_vel_y),
    .last       (ring_out.last),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

[hdl/rsg_checker.sv]
`default_nettype none
module rsg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic cfg_ready
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one object at a time
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a stalled result keeps its last flag
  a_out_last_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_last))
    else $error("last changed while stalled");

  // input is only taken once the previous ring has its last member out
  a_last_before_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) && out_valid |-> out_last)
    else $error("ready before ring finished");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind ring_spawn_generator rsg_checker u_rsg_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (obj_in.valid),
  .in_ready (obj_in.ready),
  .out_valid(ring_out.valid),
  .out_ready(ring_out.ready),
  .out_last (ring_out.last),
  .cfg_ready(cfg.ready)
);
`default_nettype wire
